/* rtl/core/pce_pkg.sv */
// package for the punctured convolutional encoder: constants, types and helpers
`default_nettype none

package pce_pkg;

	localparam int CONSTRAINT_LENGTH_DEF = 7;
	localparam int BYTE_W                = 8;
	localparam int GEN_W                 = 7;
	localparam int PEND_W                = 7;
	localparam int CNT_W                 = 3;
	localparam int IDX_W                 = 8;
	localparam int PHASE_W               = 3;
	localparam int PUNCT_PERIOD          = 6;
	localparam int CFG_IDX_W             = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CODE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_A     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_B     = 2'd2;

	localparam logic [GEN_W-1:0] GEN_A_RST = 7'd121;
	localparam logic [GEN_W-1:0] GEN_B_RST = 7'd91;

	typedef struct packed {
		logic             code_rate;
		logic [GEN_W-1:0] gen_a;
		logic [GEN_W-1:0] gen_b;
	} pce_cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             last;
	} pce_ctl_t;

	// coded bit position of the k-th kept bit, puncture pattern entered at offset q
	function automatic logic [IDX_W-1:0] kept_index(input logic [5:0] k, input logic [1:0] q);
		logic [IDX_W-1:0] m;
		logic [IDX_W-1:0] h;
		m = IDX_W'(k) + IDX_W'(q);
		h = m >> 1;
		return h + h + h + (m & IDX_W'(1)) - IDX_W'(q);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/punctured_convolutional_encoder.sv */
// top level of the punctured convolutional encoder
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[6:0]
//  in       in         in_valid / in_ready     data_byte[7:0], frame_end
//  out      out        out_valid / out_ready   coded_byte[7:0], frame_last
//
// an input byte is encoded in the cycle it is taken; its coded bytes appear from the
// next cycle, one per cycle while out_ready is high, from the result register
// (two at rate one half, one or two at rate three quarters, three or four on a frame end)
// a new byte is taken in the cycle the last waiting coded byte leaves
// out_ready low holds the result register and with it in_ready; cfg_ready is always high
// reset restores rate one half with the default generators and a clear encoder
`default_nettype none

module punctured_convolutional_encoder #(
	parameter int CONSTRAINT_LENGTH = pce_pkg::CONSTRAINT_LENGTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pce_pkg::GEN_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           frame_end,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [7:0]                          coded_byte,
	output logic                                frame_last
);

	localparam int WS = ((pce_pkg::PEND_W + 2 * (7 + CONSTRAINT_LENGTH) + 7) / 8) * 8;

	pce_pkg::pce_cfg_t cfg_q;
	pce_pkg::pce_ctl_t ctl;
	logic [WS-1:0]     stream;
	logic              cfg_wr;
	logic              clear;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign accept    = in_valid && in_ready;

	always_comb begin
		clear = 1'b0;
		unique case (cfg_index)
			pce_pkg::REG_CODE_RATE: clear = cfg_wr;
			default: clear = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_rate <= 1'b0;
			cfg_q.gen_a     <= pce_pkg::GEN_A_RST;
			cfg_q.gen_b     <= pce_pkg::GEN_B_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				pce_pkg::REG_CODE_RATE: cfg_q.code_rate <= cfg_data[0];
				pce_pkg::REG_GEN_A:     cfg_q.gen_a     <= cfg_data;
				pce_pkg::REG_GEN_B:     cfg_q.gen_b     <= cfg_data;
				default: ;
			endcase
		end
	end

	pce_encoder #(
		.CONSTRAINT_LENGTH(CONSTRAINT_LENGTH)
	) u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.clear     (clear),
		.accept    (accept),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.stream    (stream),
		.ctl       (ctl)
	);

	pce_out_buf #(
		.WS(WS)
	) u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.stream     (stream),
		.ctl        (ctl),
		.free       (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coded_byte (coded_byte),
		.frame_last (frame_last)
	);

	// a frame end always produces at least one coded byte
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> out_valid)
		else $error("frame end produced no coded byte");

	// a new byte is taken only once every waiting coded byte is gone
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("input taken while coded bytes still wait");

	// at rate one half every byte that does not end a frame yields two coded bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !frame_end && !cfg_q.code_rate |=> out_valid && !in_ready)
		else $error("rate one half byte did not yield two coded bytes");

endmodule

`default_nettype wire

/* rtl/core/pce_encoder.sv */
// encoder state, generator parities, puncturing and bit packing for one byte
`default_nettype none

module pce_encoder #(
	parameter int CONSTRAINT_LENGTH = pce_pkg::CONSTRAINT_LENGTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pce_pkg::pce_cfg_t   cfg,
	input  wire logic                clear,
	input  wire logic                accept,
	input  wire logic [7:0]          data_byte,
	input  wire logic                frame_end,
	output logic [((pce_pkg::PEND_W + 2 * (7 + CONSTRAINT_LENGTH) + 7) / 8) * 8 - 1:0] stream,
	output pce_pkg::pce_ctl_t        ctl
);

	localparam int K         = CONSTRAINT_LENGTH;
	localparam int HW        = K - 1;
	localparam int NB        = 8 + K - 1;
	localparam int SW        = HW + NB;
	localparam int KW        = 2 * NB;
	localparam int BODY_BITS = 16;
	localparam int PW        = pce_pkg::PEND_W;
	localparam int WS        = ((PW + KW + 7) / 8) * 8;
	localparam int KCW       = $clog2(KW + 1);
	localparam int CIW       = $clog2(KW);
	localparam int TW        = $clog2(PW + KW + 1);
	localparam int IW        = pce_pkg::IDX_W;
	localparam int PHW       = pce_pkg::PHASE_W;

	localparam logic [IW-1:0] D0_BODY = IW'(BODY_BITS / 3);
	localparam logic [IW-1:0] D1_BODY = IW'((BODY_BITS + 1) / 3);
	localparam logic [IW-1:0] D2_BODY = IW'((BODY_BITS + 2) / 3);
	localparam logic [IW-1:0] D0_FULL = IW'(KW / 3);
	localparam logic [IW-1:0] D1_FULL = IW'((KW + 1) / 3);
	localparam logic [IW-1:0] D2_FULL = IW'((KW + 2) / 3);
	localparam logic [PHW:0]  PH_STEP = (PHW + 1)'(BODY_BITS % pce_pkg::PUNCT_PERIOD);
	localparam logic [PHW:0]  PH_WRAP = (PHW + 1)'(pce_pkg::PUNCT_PERIOD);

	logic [HW-1:0]  hist_q;
	logic [PHW-1:0] phase_q;
	logic [PW-1:0]  pbits_q;
	logic [2:0]     pcnt_q;

	logic [SW-1:0]  seq;
	logic [K-1:0]   ga;
	logic [K-1:0]   gb;
	logic [KW-1:0]  coded;
	logic [KW-1:0]  kv;
	logic [1:0]     q;
	logic [IW-1:0]  n_coded;
	logic [IW-1:0]  drops;
	logic [IW-1:0]  kept;
	logic [IW-1:0]  idx;
	logic [TW-1:0]  total;
	logic [TW-4:0]  full;
	logic [WS-1:0]  s_kept;
	logic [PW-1:0]  pnew;
	logic [PHW:0]   psum;
	logic [PHW-1:0] phase_nx;

	always_comb begin
		ga = K'(cfg.gen_a);
		gb = K'(cfg.gen_b);

		// oldest bit at the bottom, data msb first, then the zero tail
		seq = '0;
		seq[HW-1:0] = hist_q;
		for (int i = 0; i < 8; i++) begin
			seq[HW + i] = data_byte[7 - i];
		end

		for (int i = 0; i < NB; i++) begin
			coded[2 * i]     = ^(seq[i +: K] & ga);
			coded[2 * i + 1] = ^(seq[i +: K] & gb);
		end

		n_coded = frame_end ? IW'(KW) : IW'(BODY_BITS);
		q = (phase_q >= PHW'(3)) ? 2'(phase_q - PHW'(3)) : 2'(phase_q);

		case (q)
			2'd0:    drops = frame_end ? D0_FULL : D0_BODY;
			2'd1:    drops = frame_end ? D1_FULL : D1_BODY;
			default: drops = frame_end ? D2_FULL : D2_BODY;
		endcase

		kept = cfg.code_rate ? (n_coded - drops) : n_coded;

		// kept bits left-aligned, earliest in the msb, zero past the kept count
		kv = '0;
		for (int k = 0; k < KW; k++) begin
			idx = pce_pkg::kept_index(6'(k), q);
			if (!cfg.code_rate) begin
				kv[KW - 1 - k] = (IW'(k) < n_coded) ? coded[k] : 1'b0;
			end else begin
				kv[KW - 1 - k] = (idx < n_coded) ? coded[idx[CIW-1:0]] : 1'b0;
			end
		end

		s_kept = {kv, (WS - KW)'(0)} >> pcnt_q;
		stream = {pbits_q, (WS - PW)'(0)} | s_kept;
		total  = TW'(pcnt_q) + TW'(kept[KCW-1:0]);
		full   = total[TW-1:3];

		pnew = '0;
		for (int f = 0; f < WS / 8; f++) begin
			if (full == (TW - 3)'(f)) begin
				pnew = stream[WS - 1 - 8 * f -: PW];
			end
		end

		ctl.count = pce_pkg::CNT_W'(full) +
			pce_pkg::CNT_W'(frame_end && (total[2:0] != 3'd0));
		ctl.last  = frame_end;

		psum = {1'b0, phase_q} + PH_STEP;
		if (!cfg.code_rate) begin
			phase_nx = phase_q;
		end else if (psum >= PH_WRAP) begin
			phase_nx = PHW'(psum - PH_WRAP);
		end else begin
			phase_nx = PHW'(psum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			phase_q <= '0;
			pbits_q <= '0;
			pcnt_q  <= '0;
		end else if (clear || (accept && frame_end)) begin
			hist_q  <= '0;
			phase_q <= '0;
			pbits_q <= '0;
			pcnt_q  <= '0;
		end else if (accept) begin
			hist_q  <= seq[8 +: HW];
			phase_q <= phase_nx;
			pbits_q <= pnew;
			pcnt_q  <= total[2:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pce_out_buf.sv */
// result register that hands out the packed coded bytes one transaction at a time
`default_nettype none

module pce_out_buf #(
	parameter int WS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic [WS-1:0]     stream,
	input  wire pce_pkg::pce_ctl_t ctl,
	output logic                   free,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             coded_byte,
	output logic                   frame_last
);

	localparam int CW = pce_pkg::CNT_W;

	logic [WS-1:0] data_q;
	logic [CW-1:0] cnt_q;
	logic          last_q;
	logic          take;

	assign out_valid  = (cnt_q != '0);
	assign take       = out_valid && out_ready;
	assign free       = (cnt_q == '0) || ((cnt_q == CW'(1)) && out_ready);
	assign coded_byte = data_q[WS-1 -: 8];
	assign frame_last = last_q && (cnt_q == CW'(1));

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= stream;
		end else if (take) begin
			data_q <= {data_q[WS-9:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= ctl.count;
			last_q <= ctl.last;
		end else if (take) begin
			cnt_q  <= cnt_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

/* sim/pce_stream_checker.sv */
`timescale 1ns / 100ps
// stream checker for the punctured convolutional encoder: predicts coded bytes and compares them
module pce_stream_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pce_pkg::GEN_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          frame_end,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [7:0]                    coded_byte,
	input  logic                          frame_last,
	output int                            outstanding,
	output int                            mismatches,
	output int                            compared
);

	localparam logic [5:0]                KEEP_PATTERN = 6'b110110;
	localparam logic [pce_pkg::GEN_W-1:0] RESET_GEN_A  = 7'd121;
	localparam logic [pce_pkg::GEN_W-1:0] RESET_GEN_B  = 7'd91;
	localparam int                        FLUSH_LEN    = 6;

	typedef struct packed {
		logic [7:0] coded;
		logic       last;
	} coded_item_t;

	coded_item_t coded_q[$];

	logic                      rate_34;
	logic [pce_pkg::GEN_W-1:0] poly_a;
	logic [pce_pkg::GEN_W-1:0] poly_b;
	logic [5:0]                shift_hist;
	logic [2:0]                punct_pos;
	logic [6:0]                held_bits;
	logic [2:0]                held_cnt;
	logic [63:0]               bit_acc;
	int                        bit_cnt;

	task automatic clear_encoder();
		shift_hist = '0;
		punct_pos  = '0;
		held_bits  = '0;
		held_cnt   = '0;
	endtask

	// puncturer: the keep pattern runs on across bytes at rate three quarters
	task automatic keep_bit(input logic b);
		logic keep;
		keep = 1'b1;
		if (rate_34) begin
			keep      = KEEP_PATTERN[3'd5 - punct_pos];
			punct_pos = (punct_pos == 3'd5) ? 3'd0 : punct_pos + 3'd1;
		end
		if (keep) begin
			bit_acc = {bit_acc[62:0], b};
			bit_cnt++;
		end
	endtask

	task automatic shift_in(input logic b);
		logic [6:0] window;
		window = {b, shift_hist};
		keep_bit(^(window & poly_a));
		keep_bit(^(window & poly_b));
		shift_hist = window[6:1];
	endtask

	task automatic encode_byte(input logic [7:0] d, input logic fe);
		coded_item_t item;
		bit_acc = 64'(held_bits);
		bit_cnt = held_cnt;
		for (int i = 7; i >= 0; i--)
			shift_in(d[i]);
		if (fe)
			for (int i = 0; i < FLUSH_LEN; i++)
				shift_in(1'b0);
		while (bit_cnt >= 8) begin
			bit_cnt   -= 8;
			item.coded = 8'(bit_acc >> bit_cnt);
			item.last  = fe && bit_cnt == 0;
			coded_q    = {coded_q, item};
		end
		bit_acc &= (64'd1 << bit_cnt) - 64'd1;
		if (fe) begin
			if (bit_cnt > 0) begin
				item.coded = 8'(bit_acc << (8 - bit_cnt));
				item.last  = 1'b1;
				coded_q    = {coded_q, item};
			end
			clear_encoder();
		end else begin
			held_bits = bit_acc[6:0];
			held_cnt  = 3'(bit_cnt);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		coded_item_t want;
		if (!arst_n) begin
			rate_34    = 1'b0;
			poly_a     = RESET_GEN_A;
			poly_b     = RESET_GEN_B;
			mismatches = 0;
			compared   = 0;
			clear_encoder();
			coded_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				compared++;
				if (coded_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transaction, expected none, got %02h last %0b",
						$time, coded_byte, frame_last);
				end else begin
					want = coded_q.pop_front();
					if (coded_byte !== want.coded) begin
						mismatches++;
						$display("%0t: coded_byte expected %02h, got %02h",
							$time, want.coded, coded_byte);
					end
					if (frame_last !== want.last) begin
						mismatches++;
						$display("%0t: frame_last expected %0b, got %0b",
							$time, want.last, frame_last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pce_pkg::REG_CODE_RATE: begin
						rate_34 = cfg_data[0];
						clear_encoder();
					end
					pce_pkg::REG_GEN_A: poly_a = cfg_data;
					pce_pkg::REG_GEN_B: poly_b = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				encode_byte(data_byte, frame_end);
		end
		outstanding <= coded_q.size();
	end

endmodule

/* sim/tb_punctured_convolutional_encoder.sv */
`timescale 1ns / 100ps
// testbench top for the punctured convolutional encoder: stimulus, flow control and verdict
module tb_punctured_convolutional_encoder;

	localparam logic [pce_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 11;
	localparam int PHASE_ITEMS   = 33;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [pce_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pce_pkg::GEN_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    data_byte;
	logic                          frame_end;
	logic                          out_valid;
	logic                          out_ready;
	logic [7:0]                    coded_byte;
	logic                          frame_last;

	int   outstanding;
	int   mismatches;
	int   compared;
	int   tx_idle_pct = 36;
	int   rx_idle_pct = 76;
	logic hold_out    = 1'b0;
	logic cur_rate    = 1'b0;
	int   frame_left  = 0;
	int   bytes_sent  = 0;
	int   frames_sent = 0;
	int   writes_done = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	punctured_convolutional_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coded_byte (coded_byte),
		.frame_last (frame_last)
	);

	pce_stream_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coded_byte  (coded_byte),
		.frame_last  (frame_last),
		.outstanding (outstanding),
		.mismatches  (mismatches),
		.compared    (compared)
	);

	// output side: random back-pressure plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_item(input logic [7:0] d, input logic fe);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		frame_end <= fe;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
		if (fe)
			frames_sent++;
	endtask

	task automatic send_random();
		if (frame_left == 0)
			frame_left = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 9);
		frame_left--;
		send_item(8'($urandom), frame_left == 0);
	endtask

	// leaves cfg_valid high so back-to-back writes need no gap
	task automatic write_reg(input logic [pce_pkg::CFG_IDX_W-1:0] idx,
			input logic [pce_pkg::GEN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		writes_done++;
	endtask

	task automatic apply_settings(input logic rate, input logic [pce_pkg::GEN_W-1:0] ga,
			input logic [pce_pkg::GEN_W-1:0] gb);
		logic [pce_pkg::GEN_W-1:0] rate_word;
		rate_word    = pce_pkg::GEN_W'($urandom);
		rate_word[0] = rate;
		if (rate != cur_rate || $urandom_range(1) == 1)
			write_reg(pce_pkg::REG_CODE_RATE, rate_word);
		write_reg(pce_pkg::REG_GEN_A, ga);
		write_reg(pce_pkg::REG_GEN_B, gb);
		cfg_valid <= 1'b0;
		cur_rate = rate;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		frame_end <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, rate one half
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item(8'h80, 1'b0);
		send_item(8'h01, 1'b1);
		send_item(8'hA5, 1'b0);
		send_item(8'h5A, 1'b0);
		send_item(8'hFF, 1'b1);

		// rate three quarters, pattern carried across bytes
		settle();
		apply_settings(1'b1, 7'd121, 7'd91);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);
		send_item(8'h12, 1'b0);
		send_item(8'h34, 1'b0);
		send_item(8'h56, 1'b0);
		send_item(8'h78, 1'b1);
		send_item(8'hC3, 1'b1);

		// rate write inside a frame drops the partial frame
		send_item(8'h9E, 1'b0);
		settle();
		write_reg(pce_pkg::REG_CODE_RATE, 7'd1);
		cfg_valid <= 1'b0;
		send_item(8'h3C, 1'b1);

		// generator change inside a frame keeps the encoder state
		send_item(8'h81, 1'b0);
		settle();
		write_reg(pce_pkg::REG_GEN_A, 7'd127);
		write_reg(pce_pkg::REG_GEN_B, 7'd0);
		cfg_valid <= 1'b0;
		send_item(8'h7E, 1'b1);

		settle();
		apply_settings(1'b0, 7'd0, 7'd127);
		send_item(8'hFF, 1'b1);
		send_item(8'h55, 1'b1);

		// unmapped register index
		settle();
		write_reg(REG_SPARE, 7'h55);
		cfg_valid <= 1'b0;
		send_item(8'hAA, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: apply_settings(1'b1, 7'd121, 7'd91);
				1: apply_settings(1'b0, 7'd0, 7'd127);
				2: apply_settings(1'b1, 7'd127, 7'd0);
				3: apply_settings(1'b1, 7'd0, 7'd0);
				4: apply_settings(1'b0, 7'd127, 7'd127);
				default: apply_settings(1'($urandom_range(1)), pce_pkg::GEN_W'($urandom),
					pce_pkg::GEN_W'($urandom));
			endcase
			tx_idle_pct = (p < 4) ? 36 : (p < 8) ? 76 : 0;
			rx_idle_pct = (p < 4) ? 76 : (p < 8) ? 36 : 0;
			if (p == 9)
				hold_out = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 6 && i == PHASE_ITEMS / 2)
					drain();
				send_random();
			end
		end

		drain();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d data bytes in %0d closed frames with %0d register writes",
			bytes_sent, frames_sent, writes_done);
		$display("%0d coded bytes compared across both code rates and several generator pairs",
			compared);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
